/* design/fds_pkg.sv */
`timescale 1ns / 1ps

package fds_pkg;

  localparam int unsigned PctW = 7;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [PctW-1:0] FullPct = 7'd100;
  localparam logic [PctW-1:0] OnMargin = 7'd10;
  localparam logic [PctW-1:0] OffLevel = 7'd5;

  localparam logic [PctW-1:0] MinPctReset = 7'd20;
  localparam logic [PctW-1:0] MaxPctReset = 7'd100;

  typedef enum logic [PhaseW-1:0] {
    PHASE_IDLE   = 3'd0,
    PHASE_BOOST  = 3'd1,
    PHASE_SAFETY = 3'd2
  } phase_code_t;

  typedef enum logic [1:0] {
    REG_MIN_PCT  = 2'd0,
    REG_MAX_PCT  = 2'd1,
    REG_NEVER_OFF = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [PctW-1:0] min_percent;
    logic [PctW-1:0] max_percent;
    logic            never_off_mode;
  } cfg_t;

  function automatic logic [PctW-1:0] cap_full(input logic [PctW-1:0] v);
    return (v > FullPct) ? FullPct : v;
  endfunction

endpackage

/* design/fds_regs.sv */
`timescale 1ns / 1ps

module fds_regs
  import fds_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic       wr_en;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_index_t'(paddr[AddrW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_percent    <= MinPctReset;
      cfg.max_percent    <= MaxPctReset;
      cfg.never_off_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_MIN_PCT:   cfg.min_percent    <= pwdata[PctW-1:0];
        REG_MAX_PCT:   cfg.max_percent    <= pwdata[PctW-1:0];
        REG_NEVER_OFF: cfg.never_off_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_PCT:   prdata = {{(DataW-PctW){1'b0}}, cfg.min_percent};
      REG_MAX_PCT:   prdata = {{(DataW-PctW){1'b0}}, cfg.max_percent};
      REG_NEVER_OFF: prdata = {{(DataW-1){1'b0}}, cfg.never_off_mode};
      default:       prdata = '0;
    endcase
  end

endmodule

/* design/fds_core.sv */
`timescale 1ns / 1ps

module fds_core
  import fds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PctW-1:0]   in_demand,
  input  logic [PhaseW-1:0] in_phase,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PctW-1:0]   out_fan,
  output logic              out_running
);

  // input stage
  logic              s1_valid;
  logic [PctW-1:0]   s1_demand;
  logic [PhaseW-1:0] s1_phase;

  // smoother state
  logic [PctW-1:0]   smoothed_level;
  logic              running_flag;
  logic [PhaseW-1:0] previous_phase;

  logic              out_free;
  logic              advance;

  logic [PctW-1:0]   demand_c;
  logic [PctW-1:0]   lo;
  logic [PctW-1:0]   hi;
  logic              clear;
  logic [PctW-1:0]   sm0;
  logic              rf0;
  logic [PctW+1:0]   sum;
  logic [PctW-1:0]   smooth;
  logic [PctW:0]     on_level;
  logic              rf_on;
  logic [PctW-1:0]   fan_cap;
  logic [PctW-1:0]   smoothed_level_next;
  logic              running_flag_next;
  logic [PctW-1:0]   fan_next;

  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  always_comb begin
    demand_c = cap_full(s1_demand);
    lo       = cap_full(cfg.min_percent);
    hi       = cap_full(cfg.max_percent);
    clear    = (s1_phase != previous_phase) &&
               (s1_phase == PHASE_IDLE || s1_phase == PHASE_BOOST ||
                s1_phase == PHASE_SAFETY);
    sm0      = clear ? '0 : smoothed_level;
    rf0      = clear ? 1'b0 : running_flag;
    sum      = {2'b00, sm0} + {1'b0, sm0, 1'b0} + {2'b00, demand_c};
    smooth   = sum[PctW+1:2];
    on_level = {1'b0, lo} + {1'b0, OnMargin};
    fan_cap  = (smooth > hi) ? hi : smooth;
    rf_on    = rf0 || ({1'b0, smooth} > on_level);

    if (s1_phase == PHASE_SAFETY) begin
      smoothed_level_next = '0;
      running_flag_next   = 1'b0;
      fan_next            = '0;
    end else if (s1_phase == PHASE_BOOST) begin
      smoothed_level_next = FullPct;
      running_flag_next   = 1'b1;
      fan_next            = FullPct;
    end else begin
      smoothed_level_next = smooth;
      if (cfg.never_off_mode) begin
        running_flag_next = 1'b1;
      end else begin
        running_flag_next = rf_on && !(smooth < OffLevel);
      end
      if (!running_flag_next) begin
        fan_next = '0;
      end else if (fan_cap < lo) begin
        fan_next = lo;
      end else begin
        fan_next = fan_cap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      smoothed_level <= '0;
      running_flag   <= 1'b0;
      previous_phase <= PHASE_IDLE;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
      if (advance) begin
        smoothed_level <= smoothed_level_next;
        running_flag   <= running_flag_next;
        previous_phase <= s1_phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_demand <= in_demand;
      s1_phase  <= in_phase;
    end
    if (advance) begin
      out_fan     <= fan_next;
      out_running <= running_flag_next;
    end
  end

endmodule

/* design/fan_demand_smoother_hysteresis.sv */
`timescale 1ns / 1ps

// fan demand smoother: each request carries a demand percent and the burn phase and yields
// one fan percent with the running flag. a request is taken every clock cycle unless a
// stalled result blocks a full input register; a request passes the input register, then
// the result register; the single smoother update between them sets the one-per-cycle
// rate, and a stalled result is held while one more request waits in the input register.

module fan_demand_smoother_hysteresis
  import fds_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // demand[6:0], zero[7]
  input  logic [2:0]       s_tuser,   // burn_state[2:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // fan_percent[6:0], fan_running[7]
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t            cfg;
  logic [PctW-1:0] fan_percent;
  logic            fan_running;

  fds_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fds_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_demand   (s_tdata[PctW-1:0]),
    .in_phase    (s_tuser),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_fan     (fan_percent),
    .out_running (fan_running)
  );

  assign m_tdata = {fan_running, fan_percent};

endmodule
